// ===== rtl/nnsc_pkg.sv =====
// Shared types and constants for the NV12 nearest-neighbor scaler.
// No dependencies; every other file but nnsc_if refers to this package by scoped names.
package nnsc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_ENABLE     = 3'd0;
   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_SRC_FORMAT = 3'd3;
   localparam logic [2:0] CSR_DST_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_DST_HEIGHT = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;

   // request kinds and layouts
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;
   localparam logic FMT_NV12 = 1'b0;
   localparam logic FMT_YUYV = 1'b1;

   localparam int NUM_W  = 15;  // x*sw and y*sh products
   localparam int ADDR_W = 17;  // unwrapped byte address

   localparam int DEF_MAX_SRC_WIDTH  = 128;
   localparam int DEF_MAX_SRC_HEIGHT = 64;
   localparam int DEF_STORE_BYTES    = 16384;

   typedef struct packed {
      logic              is_read;
      logic [1:0]        status;
      logic              plane;
      logic              v;
      logic [NUM_W-1:0]  rem_x;
      logic [NUM_W-1:0]  rem_y;
      logic [7:0]        qx;
      logic [7:0]        qy;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } nnsc_item_type;

endpackage

// ===== rtl/nnsc_if.sv =====
// Request and response channel interfaces for the scaler.
// Valid/ready handshake; no package dependency.
interface nnsc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [13:0] load_addr;
   logic [7:0]  load_byte;
   logic        plane;
   logic [6:0]  out_x;
   logic [5:0]  out_y;

   modport source (output valid, req_type, load_addr, load_byte, plane, out_x, out_y,
                   input ready);
   modport sink   (input valid, req_type, load_addr, load_byte, plane, out_x, out_y,
                   output ready);
endinterface

interface nnsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;
   logic [1:0] status;

   modport source (output valid, sample_byte, status, input ready);
   modport sink   (input valid, sample_byte, status, output ready);
endinterface

// ===== rtl/nnsc_div_stage.sv =====
// One pipelined restoring-division stage: two quotient bits for x and y.
// Depends on nnsc_pkg (item struct).
module nnsc_div_stage #(
   parameter int BIT_HI = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             w,
   input  logic [6:0]             h,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nnsc_pkg::nnsc_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nnsc_pkg::nnsc_item_type out_item
);

   logic                    valid_ff;
   nnsc_pkg::nnsc_item_type item_ff;
   nnsc_pkg::nnsc_item_type item_in;

   always_comb begin
      logic [15:0] dx;
      logic [15:0] dy;
      item_in = in_item;
      for (int k = 0; k < 2; k++) begin
         dx = {8'd0, w} << (BIT_HI - k);
         dy = {9'd0, h} << (BIT_HI - k);
         if ({1'b0, item_in.rem_x} >= dx) begin
            item_in.rem_x = item_in.rem_x - dx[nnsc_pkg::NUM_W-1:0];
            item_in.qx    = item_in.qx | (8'd1 << (BIT_HI - k));
         end
         if ({1'b0, item_in.rem_y} >= dy) begin
            item_in.rem_y = item_in.rem_y - dy[nnsc_pkg::NUM_W-1:0];
            item_in.qy    = item_in.qy | (8'd1 << (BIT_HI - k));
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/nnsc_addr_gen.sv =====
// Address stage: clamps the scaled coordinate and forms the byte address.
// Depends on nnsc_pkg (item struct, codes, widths).
module nnsc_addr_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             sw,
   input  logic [6:0]             sh,
   input  logic                   fmt,
   input  logic [14:0]            plane_base,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nnsc_pkg::nnsc_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nnsc_pkg::nnsc_item_type out_item
);

   localparam int AW = nnsc_pkg::ADDR_W;

   logic                    valid_ff;
   nnsc_pkg::nnsc_item_type item_ff;
   nnsc_pkg::nnsc_item_type item_in;

   always_comb begin
      logic [7:0]  sx_l;
      logic [6:0]  sy_l;
      logic [7:0]  sx_c;
      logic [7:0]  sy_c;
      logic [7:0]  sy_2;
      logic [6:0]  row;
      logic [14:0] prod;
      logic [AW-1:0] sx;
      sx_l = (in_item.qx > sw - 8'd1) ? sw - 8'd1 : in_item.qx;
      sy_l = (in_item.qy[6:0] > sh - 7'd1) ? sh - 7'd1 : in_item.qy[6:0];
      // chroma: even pair positions, clamped to the last full pair
      if (sw < 8'd2) begin
         sx_c = 8'd0;
      end else begin
         sx_c = ({in_item.qx[7:1], 1'b0} > sw - 8'd2) ? sw - 8'd2 : {in_item.qx[7:1], 1'b0};
      end
      sy_2 = {in_item.qy[6:0], 1'b0};
      if (sh < 7'd2) begin
         sy_c = 8'd0;
      end else begin
         sy_c = (sy_2 > {1'b0, sh} - 8'd2) ? {1'b0, sh} - 8'd2 : sy_2;
      end
      if (!in_item.plane) begin
         row = sy_l;
         sx  = AW'(sx_l);
      end else if (fmt == nnsc_pkg::FMT_NV12) begin
         row = sy_c[7:1];
         sx  = AW'(sx_c);
      end else begin
         row = sy_c[6:0];
         sx  = AW'(sx_c);
      end
      prod = 15'({8'd0, row} * {7'd0, sw});
      item_in = in_item;
      if (in_item.is_read) begin
         unique case ({in_item.plane, fmt})
            {1'b0, nnsc_pkg::FMT_NV12}: item_in.addr = AW'(prod) + sx;
            {1'b0, nnsc_pkg::FMT_YUYV}: item_in.addr =
               ((AW'(prod) + {sx[AW-1:1], 1'b0}) << 1) + {{(AW-2){1'b0}}, sx[0], 1'b0};
            {1'b1, nnsc_pkg::FMT_NV12}: item_in.addr =
               AW'(plane_base) + AW'(prod) + sx + AW'(in_item.v);
            default: item_in.addr =
               ((AW'(prod) + sx) << 1) + {{(AW-2){1'b0}}, in_item.v, 1'b1};
         endcase
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/nnsc_addr_wrap.sv =====
// Two-stage address wrap modulo the store size (reciprocal multiply + fixup, or pass-through).
// Depends on nnsc_pkg (item struct, address width).
module nnsc_addr_wrap #(
   parameter int STORE_BYTES = nnsc_pkg::DEF_STORE_BYTES,
   parameter int MEM_AW      = $clog2(STORE_BYTES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nnsc_pkg::nnsc_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nnsc_pkg::nnsc_item_type out_item,
   output logic [MEM_AW-1:0]      out_index
);

   localparam int AW = nnsc_pkg::ADDR_W;

   logic                    a_valid_ff;
   nnsc_pkg::nnsc_item_type a_item_ff;
   logic                    b_valid_ff;
   nnsc_pkg::nnsc_item_type b_item_ff;
   logic [MEM_AW-1:0]       b_index_ff;
   logic [MEM_AW-1:0]       index_in;
   logic                    b_ready;

   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || b_ready;

   if (STORE_BYTES >= (1 << AW)) begin : g_pass
      assign index_in = MEM_AW'(a_item_ff.addr);
   end else begin : g_recip
      localparam int SH = AW + $clog2(STORE_BYTES);
      localparam longint unsigned RECIP = (longint'(1) << SH) / longint'(STORE_BYTES);
      localparam logic [AW:0]   RECIP_V = (AW + 1)'(RECIP);
      localparam logic [AW-1:0] N_V     = AW'(STORE_BYTES);
      logic [AW-1:0] q_ff;
      logic [AW-1:0] q_in;
      logic [2*AW:0] prod;
      logic [AW-1:0] rem;
      logic [AW-1:0] rem_fix;

      assign prod    = {{(AW){1'b0}}, in_item.addr} * {{(AW){1'b0}}, RECIP_V};
      assign q_in    = AW'(prod >> SH);
      assign rem     = a_item_ff.addr - AW'(q_ff * N_V);
      assign rem_fix = (rem >= N_V) ? rem - N_V : rem;
      assign index_in = MEM_AW'(rem_fix);

      always_ff @(posedge clock) begin
         if (in_ready && in_valid) begin
            q_ff <= q_in;
         end
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;
   assign out_index = b_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) a_valid_ff <= in_valid;
         if (b_ready)  b_valid_ff <= a_valid_ff;
      end
      if (in_ready && in_valid) begin
         a_item_ff <= in_item;
      end
      if (b_ready && a_valid_ff) begin
         b_item_ff  <= a_item_ff;
         b_index_ff <= index_in;
      end
   end

endmodule

// ===== rtl/nnsc_frame_store.sv =====
// Frame store memory with registered read and the response output register.
// Depends on nnsc_pkg (item struct, status codes).
module nnsc_frame_store #(
   parameter int STORE_BYTES = nnsc_pkg::DEF_STORE_BYTES,
   parameter int MEM_AW      = $clog2(STORE_BYTES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nnsc_pkg::nnsc_item_type in_item,
   input  logic [MEM_AW-1:0]      in_index,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_sample,
   output logic [1:0]             out_status
);

   logic [7:0] mem [STORE_BYTES];
   logic       valid_ff;
   logic [7:0] rd_ff;
   logic [1:0] status_ff;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_status = status_ff;
   assign out_sample = (status_ff == nnsc_pkg::ST_OK) ? rd_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         // loads retire here and leave no response
         valid_ff <= in_valid && in_item.is_read;
      end
      if (in_ready && in_valid) begin
         if (!in_item.is_read) begin
            mem[in_index] <= in_item.data;
         end else begin
            rd_ff     <= mem[in_index];
            status_ff <= in_item.status;
         end
      end
   end

endmodule

// ===== rtl/nv12_nearest_neighbor_scaler_top.sv =====
// Top level of the NV12/YUYV nearest-neighbor thumbnail scaler.
// Depends on nnsc_pkg, nnsc_if and the nnsc_* stage modules.

// One request enters per clock when not stalled; a load writes one byte into
// the frame store; a read maps a thumbnail plane/column/row to a source byte by
// nearest-neighbor scaling and returns it with a status (ok, empty, outside).
// Every request passes a 9-stage pipeline: operand multiply, four division
// stages (two quotient bits each), address form, two address-wrap stages and
// the frame store read. The accepting edge loads stage 1; a read's response
// is valid once the frame store has registered it.
// Loads and reads reach the store in request order, so a read always sees
// every earlier load. Throughput is one request per cycle, set by the single
// store port used once per request; a stalled response only backs up stages
// that are full. The store has no reset: read only bytes already loaded.
// Write configuration only while no request is in flight.
module nv12_nearest_neighbor_scaler_top #(
   parameter int MAX_SRC_WIDTH  = nnsc_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = nnsc_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int STORE_BYTES    = nnsc_pkg::DEF_STORE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   nnsc_req_if.sink   req_if,
   nnsc_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   localparam int MEM_AW = $clog2(STORE_BYTES);
   localparam logic [12:0] MAX_W = 13'(MAX_SRC_WIDTH);
   localparam logic [12:0] MAX_H = 13'(MAX_SRC_HEIGHT);

   // ---------------- configuration registers ----------------
   logic        enable_ff;
   logic [7:0]  src_width_ff;
   logic [6:0]  src_height_ff;
   logic        src_format_ff;
   logic [7:0]  dst_width_ff;
   logic [6:0]  dst_height_ff;
   logic [14:0] plane_base_ff;   // sw*sh, start of the NV12 chroma plane

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         src_width_ff  <= 8'd0;
         src_height_ff <= 7'd0;
         src_format_ff <= 1'b0;
         dst_width_ff  <= 8'd0;
         dst_height_ff <= 7'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            nnsc_pkg::CSR_ENABLE:     enable_ff     <= csr_wr_data[0];
            nnsc_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wr_data;
            nnsc_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wr_data[6:0];
            nnsc_pkg::CSR_SRC_FORMAT: src_format_ff <= csr_wr_data[0];
            nnsc_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_wr_data;
            nnsc_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   // saturated source size, even thumbnail size
   logic [7:0] sw;
   logic [6:0] sh;
   logic [7:0] w;
   logic [6:0] h;
   logic       empty;

   assign sw = ({5'd0, src_width_ff} > MAX_W) ? MAX_W[7:0] : src_width_ff;
   assign sh = ({6'd0, src_height_ff} > MAX_H) ? MAX_H[6:0] : src_height_ff;
   assign w  = {dst_width_ff[7:1], 1'b0};
   assign h  = {dst_height_ff[6:1], 1'b0};
   assign empty = !enable_ff || sw == 8'd0 || sh == 7'd0 || w == 8'd0 || h == 7'd0;

   // the user must keep config static while requests fly (not enforced here), so a lagging product is fine
   always_ff @(posedge clock) begin
      plane_base_ff <= 15'({7'd0, sw} * {8'd0, sh});
   end

   // ---------------- stage 1: operands and status ----------------
   logic                    s1_valid_ff;
   nnsc_pkg::nnsc_item_type s1_ff;
   nnsc_pkg::nnsc_item_type s1_in;
   logic                    s1_ready;

   always_comb begin
      logic [6:0] xs;
      logic [6:0] hlim;
      logic       outside;
      xs   = req_if.plane ? {req_if.out_x[6:1], 1'b0} : req_if.out_x;
      hlim = req_if.plane ? {1'b0, h[6:1]} : h;
      outside = ({1'b0, req_if.out_x} >= w) || ({1'b0, req_if.out_y} >= hlim);
      s1_in         = '0;
      s1_in.is_read = (req_if.req_type == nnsc_pkg::REQ_READ);
      s1_in.plane   = req_if.plane;
      s1_in.v       = req_if.out_x[0];
      s1_in.rem_x   = nnsc_pkg::NUM_W'({8'd0, xs} * {7'd0, sw});
      s1_in.rem_y   = nnsc_pkg::NUM_W'({7'd0, req_if.out_y} * {6'd0, sh});
      s1_in.addr    = nnsc_pkg::ADDR_W'(req_if.load_addr);
      s1_in.data    = req_if.load_byte;
      priority if (empty) begin
         s1_in.status = nnsc_pkg::ST_EMPTY;
      end else if (outside) begin
         s1_in.status = nnsc_pkg::ST_OUTSIDE;
      end else begin
         s1_in.status = nnsc_pkg::ST_OK;
      end
   end

   logic                    dv   [5];
   logic                    drdy [5];
   nnsc_pkg::nnsc_item_type dit  [5];

   assign s1_ready     = !s1_valid_ff || drdy[0];
   assign req_if.ready = s1_ready;
   assign dv[0]        = s1_valid_ff;
   assign dit[0]       = s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_if.valid;
      end
      if (s1_ready && req_if.valid) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- stages 2-5: divide by w and h ----------------
   logic div_in_valid [4];
   for (genvar k = 0; k < 4; k++) begin : g_div
      assign div_in_valid[k] = dv[k];
      nnsc_div_stage #(.BIT_HI(7 - 2 * k)) u_div (
         .clock     (clock),
         .reset     (reset),
         .w         (w),
         .h         (h),
         .in_valid  (div_in_valid[k]),
         .in_ready  (drdy[k]),
         .in_item   (dit[k]),
         .out_valid (dv[k + 1]),
         .out_ready (drdy[k + 1]),
         .out_item  (dit[k + 1])
      );
   end

   // ---------------- stage 6: address ----------------
   logic                    ag_valid;
   logic                    wr_ready;
   nnsc_pkg::nnsc_item_type ag_item;

   nnsc_addr_gen u_addr_gen (
      .clock      (clock),
      .reset      (reset),
      .sw         (sw),
      .sh         (sh),
      .fmt        (src_format_ff),
      .plane_base (plane_base_ff),
      .in_valid   (dv[4]),
      .in_ready   (drdy[4]),
      .in_item    (dit[4]),
      .out_valid  (ag_valid),
      .out_ready  (wr_ready),
      .out_item   (ag_item)
   );

   // ---------------- stages 7-8: wrap to the store ----------------
   logic                    aw_valid;
   logic                    fs_ready;
   nnsc_pkg::nnsc_item_type aw_item;
   logic [MEM_AW-1:0]       aw_index;

   nnsc_addr_wrap #(.STORE_BYTES(STORE_BYTES), .MEM_AW(MEM_AW)) u_addr_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ag_valid),
      .in_ready  (wr_ready),
      .in_item   (ag_item),
      .out_valid (aw_valid),
      .out_ready (fs_ready),
      .out_item  (aw_item),
      .out_index (aw_index)
   );

   // ---------------- stage 9: frame store and response ----------------
   nnsc_frame_store #(.STORE_BYTES(STORE_BYTES), .MEM_AW(MEM_AW)) u_frame_store (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (aw_valid),
      .in_ready   (fs_ready),
      .in_item    (aw_item),
      .in_index   (aw_index),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_sample (rsp_if.sample_byte),
      .out_status (rsp_if.status)
   );

   // ---------------- assertions ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted request not captured in stage 1");

   a_disabled_empty: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.is_read && !enable_ff |-> s1_ff.status == nnsc_pkg::ST_EMPTY)
      else $error("read while disabled not marked empty");

   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != nnsc_pkg::ST_OK |-> rsp_if.sample_byte == 8'd0)
      else $error("nonzero sample with error status");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !drdy[0] |=> s1_valid_ff && $stable(s1_ff))
      else $error("stage 1 changed while stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for nv12_nearest_neighbor_scaler_top.
// Depends on nnsc_pkg, nnsc_if and the scaler RTL; predicts frame store reads in-line.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_N   = 16384;
   localparam int DRAIN_CYC = 12;    // pipeline is 9 deep, keep a margin
   localparam int WDOG_MAX  = 3000;  // cycles with no handshake on either side
   localparam int HOLD_CYC  = 400;   // long receiver hold-off

   typedef struct {
      logic        req_type;
      logic [13:0] load_addr;
      logic [7:0]  load_byte;
      logic        plane;
      logic [6:0]  out_x;
      logic [5:0]  out_y;
   } scaler_req_type;

   typedef struct {
      logic [7:0] sample_byte;
      logic [1:0] status;
   } scaler_rsp_type;

   logic clock;
   logic reset;
   logic       csr_wr_en;
   logic [2:0] csr_index;
   logic [7:0] csr_wr_data;

   nnsc_req_if req_ch ();
   nnsc_rsp_if rsp_ch ();

   nv12_nearest_neighbor_scaler_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // shadow of the block: registers and frame store contents
   logic [7:0] shadow_store [STORE_N];
   bit         loaded       [STORE_N];
   int unsigned cfg_enable, cfg_src_w, cfg_src_h, cfg_format, cfg_dst_w, cfg_dst_h;

   scaler_req_type pending_reqs [$];
   scaler_rsp_type expected_rsps [$];

   int sender_idle_pct;
   int recv_stall_pct;
   int hold_seq, hold_done, hold_left;
   int fail_cnt, n_loads, n_reads, n_rsps;
   int quiet_cyc;

   // Nearest-neighbor mapping of one thumbnail read. Returns the status; for
   // an ok read, addr holds the wrapped frame store address.
   function automatic logic [1:0] map_read(input logic plane, input int unsigned x,
                                           input int unsigned y, output int unsigned addr);
      int unsigned sw, sh, w, h, sx, sy, v;
      sw = (cfg_src_w > 128) ? 128 : cfg_src_w;
      sh = (cfg_src_h > 64) ? 64 : cfg_src_h;
      w  = cfg_dst_w & ~32'd1;
      h  = cfg_dst_h & ~32'd1;
      addr = 0;
      if (cfg_enable == 0 || sw == 0 || sh == 0 || w == 0 || h == 0)
         return nnsc_pkg::ST_EMPTY;
      if (plane == 1'b0) begin
         if (x >= w || y >= h) return nnsc_pkg::ST_OUTSIDE;
         sx = x * sw / w;
         sy = y * sh / h;
         if (sx > sw - 1) sx = sw - 1;
         if (sy > sh - 1) sy = sh - 1;
         if (cfg_format == nnsc_pkg::FMT_NV12) addr = sy * sw + sx;
         else addr = (sy * sw + (sx & ~32'd1)) * 2 + ((sx & 1) ? 2 : 0);
      end else begin
         if (x >= w || y >= h / 2) return nnsc_pkg::ST_OUTSIDE;
         v  = x & 1;
         sx = (((x & ~32'd1) * sw) / w) & ~32'd1;
         sy = ((y * sh / h) * 2) & ~32'd1;
         // chroma pairs clamp to the last even position
         sx = (sw < 2) ? 0 : ((sx > sw - 2) ? sw - 2 : sx);
         sy = (sh < 2) ? 0 : ((sy > sh - 2) ? sh - 2 : sy);
         if (cfg_format == nnsc_pkg::FMT_NV12) addr = sw * sh + (sy / 2) * sw + sx + v;
         else addr = (sy * sw + sx) * 2 + (v ? 3 : 1);
      end
      addr = addr % STORE_N;
      return nnsc_pkg::ST_OK;
   endfunction

   task automatic push_load(input int unsigned addr, input logic [7:0] val);
      scaler_req_type r;
      r = '{nnsc_pkg::REQ_LOAD, addr[13:0], val, 1'b0, 7'd0, 6'd0};
      shadow_store[addr] = val;
      loaded[addr] = 1'b1;
      pending_reqs.push_back(r);
      n_loads++;
   endtask

   // Queue a read; an ok read of a never-loaded byte gets a load ahead of it.
   task automatic push_read(input logic plane, input int unsigned x, input int unsigned y);
      scaler_req_type r;
      scaler_rsp_type e;
      int unsigned addr;
      logic [1:0] st;
      st = map_read(plane, x, y, addr);
      if (st == nnsc_pkg::ST_OK && !loaded[addr]) push_load(addr, 8'($urandom));
      r = '{nnsc_pkg::REQ_READ, 14'($urandom), 8'($urandom), plane, x[6:0], y[5:0]};
      e.status = st;
      e.sample_byte = (st == nnsc_pkg::ST_OK) ? shadow_store[addr] : 8'd0;
      pending_reqs.push_back(r);
      expected_rsps.push_back(e);
      n_reads++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val[7:0];
      case (idx)
         nnsc_pkg::CSR_ENABLE:     cfg_enable = val & 1;
         nnsc_pkg::CSR_SRC_WIDTH:  cfg_src_w  = val & 8'hFF;
         nnsc_pkg::CSR_SRC_HEIGHT: cfg_src_h  = val & 7'h7F;
         nnsc_pkg::CSR_SRC_FORMAT: cfg_format = val & 1;
         nnsc_pkg::CSR_DST_WIDTH:  cfg_dst_w  = val & 8'hFF;
         nnsc_pkg::CSR_DST_HEIGHT: cfg_dst_h  = val & 7'h7F;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // registers only change with nothing in flight
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned en, sw, sh, fmt, dw, dh,
                            input int n_rand, input int idle_mode);
      int unsigned w, h, x, y, xw, yh;
      logic plane;
      wait_idle();
      csr_write(nnsc_pkg::CSR_ENABLE, en);
      csr_write(nnsc_pkg::CSR_SRC_WIDTH, sw);
      csr_write(nnsc_pkg::CSR_SRC_HEIGHT, sh);
      csr_write(nnsc_pkg::CSR_SRC_FORMAT, fmt);
      csr_write(nnsc_pkg::CSR_DST_WIDTH, dw);
      csr_write(nnsc_pkg::CSR_DST_HEIGHT, dh);
      case (idle_mode)
         0: begin sender_idle_pct = 14; recv_stall_pct = 54; end
         1: begin sender_idle_pct = 54; recv_stall_pct = 14; end
         default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      w = cfg_dst_w & ~32'd1;
      h = cfg_dst_h & ~32'd1;
      // in-range picks stay inside the column and row field widths
      xw = (w > 128) ? 128 : w;
      yh = (h > 64) ? 64 : h;
      for (int i = 0; i < n_rand; i++) begin
         if ($urandom_range(0, 99) < 35) begin
            push_load($urandom_range(0, STORE_N - 1), 8'($urandom));
         end else begin
            plane = 1'($urandom);
            // mostly in-range reads, the rest anywhere in the field range
            if ($urandom_range(0, 99) < 80 && w != 0 && h >= 2) begin
               x = $urandom_range(0, xw - 1);
               y = plane ? $urandom_range(0, h / 2 - 1) : $urandom_range(0, yh - 1);
            end else begin
               x = $urandom_range(0, 127);
               y = $urandom_range(0, 63);
            end
            push_read(plane, x, y);
         end
      end
      // long receiver hold-off while the sender keeps offering
      if (idle_mode == 2) hold_seq++;
   endtask

   // driver: next request goes out whenever the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            scaler_req_type r;
            r = pending_reqs.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.req_type  <= r.req_type;
            req_ch.load_addr <= r.load_addr;
            req_ch.load_byte <= r.load_byte;
            req_ch.plane     <= r.plane;
            req_ch.out_x     <= r.out_x;
            req_ch.out_y     <= r.out_y;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: check each response against the oldest expectation, drive ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_rsps++;
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: status %0d byte %0d",
                      rsp_ch.status, rsp_ch.sample_byte);
               fail_cnt++;
            end else begin
               scaler_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_ch.status);
                  fail_cnt++;
               end
               if (rsp_ch.sample_byte !== e.sample_byte) begin
                  $error("sample_byte: expected %0d actual %0d",
                         e.sample_byte, rsp_ch.sample_byte);
                  fail_cnt++;
               end
            end
         end
         if (hold_seq != hold_done) begin
            hold_done <= hold_seq;
            hold_left <= HOLD_CYC;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cyc <= 0;
      else if (quiet_cyc >= WDOG_MAX) begin
         $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
         $display("end of test: mismatches");
         $finish;
      end else
         quiet_cyc <= quiet_cyc + 1;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = nnsc_pkg::REQ_LOAD;
      req_ch.load_addr = '0;
      req_ch.load_byte = '0;
      req_ch.plane = 1'b0;
      req_ch.out_x = '0;
      req_ch.out_y = '0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = nnsc_pkg::CSR_ENABLE;
      csr_wr_data = '0;
      cfg_enable = 0; cfg_src_w = 0; cfg_src_h = 0;
      cfg_format = 0; cfg_dst_w = 0; cfg_dst_h = 0;
      sender_idle_pct = 14; recv_stall_pct = 54;
      hold_seq = 0; hold_done = 0; hold_left = 0;
      fail_cnt = 0; n_loads = 0; n_reads = 0; n_rsps = 0; quiet_cyc = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reads straight out of reset: every register is zero, so empty
      push_read(1'b0, 0, 0);
      push_read(1'b1, 127, 63);

      // full-size NV12 with directed corners
      run_phase(1, 128, 64, nnsc_pkg::FMT_NV12, 128, 64, 0, 0);
      push_load(0, 8'h00);
      push_load(STORE_N - 1, 8'hFF);
      push_load(14'h2AAA, 8'hA5);
      push_read(1'b0, 0, 0);
      push_read(1'b0, 127, 63);
      push_read(1'b1, 0, 0);
      push_read(1'b1, 1, 0);
      push_read(1'b1, 127, 31);
      push_read(1'b1, 126, 32);   // chroma row past half height
      push_read(1'b0, 127, 63);
      push_read(1'b1, 0, 63);
      run_phase(1, 128, 64, nnsc_pkg::FMT_NV12, 128, 64, 220, 0);

      // oversized source saturates, packed layout, odd destination sizes
      run_phase(1, 255, 127, nnsc_pkg::FMT_YUYV, 41, 21, 0, 0);
      push_read(1'b0, 39, 19);
      push_read(1'b0, 40, 0);     // column past rounded width
      push_read(1'b1, 39, 9);
      push_read(1'b1, 38, 10);
      run_phase(1, 255, 127, nnsc_pkg::FMT_YUYV, 41, 21, 220, 0);

      // upscale from an odd-sized source, clamping on the last pair
      run_phase(1, 7, 5, nnsc_pkg::FMT_NV12, 9, 7, 190, 0);
      run_phase(1, 2, 2, nnsc_pkg::FMT_YUYV, 2, 2, 150, 1);
      run_phase(1, 1, 1, nnsc_pkg::FMT_NV12, 2, 2, 60, 1);

      // the empty cases: disabled, zero source, thumbnail rounding to zero
      run_phase(0, 128, 64, nnsc_pkg::FMT_NV12, 128, 64, 40, 1);
      run_phase(1, 0, 64, nnsc_pkg::FMT_NV12, 128, 64, 20, 1);
      run_phase(1, 64, 0, nnsc_pkg::FMT_YUYV, 128, 64, 20, 1);
      run_phase(1, 64, 32, nnsc_pkg::FMT_NV12, 1, 3, 30, 1);
      run_phase(1, 64, 32, nnsc_pkg::FMT_NV12, 16, 0, 20, 1);

      run_phase(1, $urandom_range(1, 255), $urandom_range(1, 127), $urandom_range(0, 1),
                $urandom_range(2, 255), $urandom_range(2, 127), 190, 1);

      // full-size packed, no idling, long receiver hold-off
      run_phase(1, 128, 64, nnsc_pkg::FMT_YUYV, 128, 64, 300, 2);

      wait_idle();
      $display("covered %0d loads and %0d reads, %0d responses checked",
               n_loads, n_reads, n_rsps);
      $display("configurations: both layouts, saturated/tiny/odd sizes, disabled and empty");
      if (fail_cnt == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
